// File: rtl/core/rmth_pkg.sv
// shared constants and cell control type for the running median block
// no dependencies
package rmth_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TOTAL_W    = 12;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_e;

  // control broadcast to every cell of one row
  typedef struct packed {
    cell_op_e op;
    logic     is_max;
    data_t    data;
  } cell_ctrl_t;

endpackage

// File: rtl/core/rmth_if.sv
// valid/ready channels for samples and results
// depends on rmth_pkg
interface rmth_in_if import rmth_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sample;
  logic  restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmth_out_if import rmth_pkg::*; ();
  logic                valid;
  logic                ready;
  data_t               median;
  logic                dropped;
  logic [TOTAL_W-1:0]  item_count;
  modport source (output valid, output median, output dropped, output item_count, input ready);
  modport sink   (input valid, input median, input dropped, input item_count, output ready);
endinterface

// File: rtl/core/running_median_two_heaps_top.sv
// Running median of an unsigned sample stream. Each accepted beat is handled in
// order: the sample is placed in the lower or upper row in the accept cycle,
// then in ST_BAL the rows are rebalanced and the result registered, and the
// result beat is offered; ST_BAL waits while an earlier result is stalled.
// The next sample is taken once the rebalance has been done, so a new sample
// can be taken while a result may still wait. Each row is a chain of 1024 cells
// kept sorted, so an insert or a root removal updates all cells at once. A
// sample for a full row is discarded and flagged; restart empties both rows
// before the sample is used.
// depends on rmth_pkg, rmth_if, rmth_heap
module running_median_two_heaps_top import rmth_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmth_in_if.sink      in_i,
  rmth_out_if.source   res_o
);
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BAL  = 2'd1
  } state_e;

  state_e     state_q;
  data_t      median_q;
  logic       have_q;
  logic       drop_q;
  logic       out_valid_q;
  data_t      out_median_q;
  logic       out_drop_q;
  logic [TOTAL_W-1:0] out_count_q;

  cell_ctrl_t lo_ctrl, up_ctrl;
  data_t      lo_root, up_root;
  cnt_t       lo_cnt, up_cnt;
  logic       accept, clear, to_upper, bal_go, full;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign clear      = accept && in_i.restart;
  assign to_upper   = in_i.sample > median_q;
  assign full       = to_upper ? (up_cnt >= cnt_t'(HEAP_DEPTH))
                               : (lo_cnt >= cnt_t'(HEAP_DEPTH));
  assign bal_go     = (state_q == ST_BAL) && !(out_valid_q && !res_o.ready);

  // row control: insert on accept, rebalance in ST_BAL
  always_comb begin
    lo_ctrl = '{op: OP_HOLD, is_max: 1'b1, data: in_i.sample};
    up_ctrl = '{op: OP_HOLD, is_max: 1'b0, data: in_i.sample};
    if (accept && have_q && !in_i.restart && !full) begin
      if (to_upper) up_ctrl.op = OP_PUSH;
      else lo_ctrl.op = OP_PUSH;
    end else if (bal_go && !drop_q) begin
      if ({1'b0, up_cnt} == {1'b0, lo_cnt} + (CNT_W+1)'(2)) begin
        lo_ctrl.op   = OP_PUSH;
        lo_ctrl.data = median_q;
        up_ctrl.op   = OP_POP;
      end else if (lo_cnt > up_cnt) begin
        up_ctrl.op   = OP_PUSH;
        up_ctrl.data = median_q;
        lo_ctrl.op   = OP_POP;
      end
    end
  end

  rmth_heap u_lower (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lo_ctrl),
    .clear_i(clear),
    .root_o (lo_root),
    .count_o(lo_cnt)
  );

  rmth_heap u_upper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (up_ctrl),
    .clear_i(clear),
    .root_o (up_root),
    .count_o(up_cnt)
  );

  // sequencer, median and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      median_q    <= '0;
      have_q      <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= bal_go || (out_valid_q && !res_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            drop_q <= have_q && !in_i.restart && full;
            if (!have_q || in_i.restart) begin
              median_q <= in_i.sample;
              have_q   <= 1'b1;
            end
            state_q <= ST_BAL;
          end
        end
        ST_BAL: begin
          if (bal_go) begin
            if (up_ctrl.op == OP_POP) median_q <= up_root;
            else if (lo_ctrl.op == OP_POP) median_q <= lo_root;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload of the result beat
  always_ff @(posedge clk_i) begin
    if (bal_go) begin
      out_drop_q  <= drop_q;
      out_count_q <= TOTAL_W'(lo_cnt) + TOTAL_W'(up_cnt) + TOTAL_W'(have_q);
      if (up_ctrl.op == OP_POP) out_median_q <= up_root;
      else if (lo_ctrl.op == OP_POP) out_median_q <= lo_root;
      else out_median_q <= median_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.median     = out_median_q;
  assign res_o.dropped    = out_drop_q;
  assign res_o.item_count = out_count_q;
endmodule

// File: rtl/core/rmth_cell.sv
// one cell of a sorted row: holds a value, inserts or shifts towards the head
// depends on rmth_pkg
module rmth_cell import rmth_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  logic       prev_above_i,
  input  data_t      prev_val_i,
  input  data_t      next_val_i,
  output data_t      val_o,
  output logic       above_o
);
  data_t val_q, val_d;

  // held value ranks ahead of the new one
  assign above_o = valid_i &&
                   (ctrl_i.is_max ? (val_q > ctrl_i.data) : (val_q < ctrl_i.data));
  assign val_o   = val_q;

  always_comb begin
    case (ctrl_i.op)
      OP_PUSH: begin
        if (above_o) val_d = val_q;
        else if (prev_above_i) val_d = ctrl_i.data;
        else val_d = prev_val_i;
      end
      OP_POP:  val_d = next_val_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
endmodule

// File: rtl/core/rmth_heap.sv
// priority row: chain of cells kept sorted, root at cell zero, plus fill count
// depends on rmth_pkg, rmth_cell
module rmth_heap import rmth_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       clear_i,
  output data_t      root_o,
  output cnt_t       count_o
);
  cnt_t  count_q;
  data_t vals [HEAP_DEPTH];
  logic  above [HEAP_DEPTH];

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic  valid;
    logic  prev_above;
    data_t prev_val;
    data_t next_val;
    assign valid = cnt_t'(i) < count_q;
    if (i == 0) begin : g_head
      assign prev_above = 1'b1;
      assign prev_val   = ctrl_i.data;
    end else begin : g_body
      assign prev_above = above[i-1];
      assign prev_val   = vals[i-1];
    end
    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end
    rmth_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .valid_i     (valid),
      .prev_above_i(prev_above),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .val_o       (vals[i]),
      .above_o     (above[i])
    );
  end

  assign root_o  = vals[0];
  assign count_o = count_q;

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else begin
      case (ctrl_i.op)
        OP_PUSH: count_q <= count_q + cnt_t'(1);
        OP_POP:  count_q <= count_q - cnt_t'(1);
        default: count_q <= count_q;
      endcase
    end
  end
endmodule

// File: rtl/core/rmth_checker.sv
// port-level checks for the running median block, bound to the top level
// depends on rmth_pkg
module rmth_checker import rmth_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input data_t              in_sample_i,
  input logic               in_restart_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input data_t              out_median_i,
  input logic               out_dropped_i,
  input logic [TOTAL_W-1:0] out_count_i
);
  logic [1:0] pend_q;
  logic       rst_seen_q;
  data_t      smp_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // count the beats in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 2'd0;
      rst_seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc) rst_seen_q <= in_restart_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) smp_q <= in_sample_i;
  end

  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_median_i))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result beat without a sample");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pend_q == 2'd1 && rst_seen_q && !in_acc |->
      out_median_i == smp_q && out_count_i == TOTAL_W'(1) && !out_dropped_i)
    else $error("restart did not restart the median");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= TOTAL_W'(2 * HEAP_DEPTH + 1) && out_count_i != '0)
    else $error("item count out of range");
endmodule

bind running_median_two_heaps_top rmth_checker u_rmth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_sample_i  (in_i.sample),
  .in_restart_i (in_i.restart),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_median_i (res_o.median),
  .out_dropped_i(res_o.dropped),
  .out_count_i  (res_o.item_count)
);
